// File: rtl/m3inv_pkg.sv
// Shared types and constants for the 3x3 matrix inverse unit.
package m3inv_pkg;

  localparam int EW = 32;
  localparam int FB = 16;

  typedef struct packed {
    logic signed [EW-1:0] a00;
    logic signed [EW-1:0] a01;
    logic signed [EW-1:0] a02;
    logic signed [EW-1:0] a10;
    logic signed [EW-1:0] a11;
    logic signed [EW-1:0] a12;
    logic signed [EW-1:0] a20;
    logic signed [EW-1:0] a21;
    logic signed [EW-1:0] a22;
  } m3inv_in_t;

  typedef struct packed {
    logic signed [EW-1:0] inv00;
    logic signed [EW-1:0] inv01;
    logic signed [EW-1:0] inv02;
    logic signed [EW-1:0] inv10;
    logic signed [EW-1:0] inv11;
    logic signed [EW-1:0] inv12;
    logic signed [EW-1:0] inv20;
    logic signed [EW-1:0] inv21;
    logic signed [EW-1:0] inv22;
    logic                 ok;
  } m3inv_out_t;

  // Product of two entries, and adjugate entry (difference of two products).
  localparam int PW = 2 * EW;
  localparam int AW = PW + 1;
  // Determinant: sum of three entry-by-adjugate products.
  localparam int DW = EW + AW + 2;
  // Numerator magnitude: |adj| << 2*FB.
  localparam int NW = AW + 2 * FB;

  // Queue entry between the front and back parts.
  typedef struct packed {
    logic signed [8:0][AW-1:0] adj;
    logic signed [DW-1:0]      det;
  } m3inv_job_t;

endpackage

// File: rtl/matrix3_inverse_unit.sv
// Top level of the 3x3 matrix inverse unit.
//
//   channel | handshake             | payload
//   in      | in_valid / in_ready   | in_data  (m3inv_in_t)
//   out     | out_valid / out_ready | out_data (m3inv_out_t)
//
// Front part: one cofactor per cycle, then three determinant products taken
// in two halves each. Back part: one shared restoring divider that works on
// one entry at a time; the divider sets the rate. A singular matrix skips
// the divider and goes straight to the output.
// Reset (rst, synchronous) empties the queue and idles both parts.
// A stalled output holds the back part; the front fills the queue until full.
module matrix3_inverse_unit
  import m3inv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  m3inv_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output m3inv_out_t out_data
);

  m3inv_job_t fj, bj;
  logic fv, fr, bv, br;

  m3inv_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  m3inv_queue u_queue (
    .clk, .rst, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(bv), .rd_ready(br), .rd_data(bj)
  );

  m3inv_back u_back (
    .clk, .rst, .job_valid(bv), .job_ready(br), .job(bj),
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: rtl/m3inv_front.sv
// Front part: forms the adjugate and determinant of an accepted matrix.
module m3inv_front
  import m3inv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  m3inv_in_t  in_data,
  output logic       job_valid,
  input  logic       job_ready,
  output m3inv_job_t job
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADJ  = 3'd1;
  localparam logic [2:0] ST_DET  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0] state;
  logic [3:0] idx;
  logic signed [8:0][EW-1:0] m;
  logic signed [8:0][AW-1:0] adj;
  logic signed [DW-1:0] det;
  logic signed [PW-1:0] pa, pb;
  logic signed [EW-1:0] x0, x1, y0, y1, dm;
  logic signed [AW-1:0] da;
  logic signed [EW:0] dh;
  logic signed [2*EW:0] dp;

  // Operand select for one cofactor per cycle: x0*x1 - y0*y1.
  always_comb begin
    x0 = m[4]; x1 = m[8]; y0 = m[5]; y1 = m[7];
    case (idx)
      4'd1: begin x0 = m[2]; x1 = m[7]; y0 = m[1]; y1 = m[8]; end
      4'd2: begin x0 = m[1]; x1 = m[5]; y0 = m[2]; y1 = m[4]; end
      4'd3: begin x0 = m[5]; x1 = m[6]; y0 = m[3]; y1 = m[8]; end
      4'd4: begin x0 = m[0]; x1 = m[8]; y0 = m[2]; y1 = m[6]; end
      4'd5: begin x0 = m[2]; x1 = m[3]; y0 = m[0]; y1 = m[5]; end
      4'd6: begin x0 = m[3]; x1 = m[7]; y0 = m[4]; y1 = m[6]; end
      4'd7: begin x0 = m[1]; x1 = m[6]; y0 = m[0]; y1 = m[7]; end
      4'd8: begin x0 = m[0]; x1 = m[4]; y0 = m[1]; y1 = m[3]; end
      default: ;
    endcase
  end

  assign pa = x0 * x1;
  assign pb = y0 * y1;

  // Determinant term idx[3:1], half idx[0]: low half unsigned, high half signed.
  always_comb begin
    dm = m[0]; da = adj[0];
    case (idx[3:1])
      3'd1: begin dm = m[1]; da = adj[3]; end
      3'd2: begin dm = m[2]; da = adj[6]; end
      default: ;
    endcase
  end

  assign dh        = idx[0] ? da[AW-1:EW] : {1'b0, da[EW-1:0]};
  assign dp        = dm * dh;
  assign in_ready  = (state == ST_IDLE);
  assign job_valid = (state == ST_DONE);
  assign job.adj   = adj;
  assign job.det   = det;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) begin
          m     <= {in_data.a22, in_data.a21, in_data.a20, in_data.a12, in_data.a11,
                    in_data.a10, in_data.a02, in_data.a01, in_data.a00};
          idx   <= '0;
          state <= ST_ADJ;
        end
        ST_ADJ: begin
          adj[idx] <= AW'(pa) - AW'(pb);
          if (idx == 4'd8) begin
            idx   <= '0;
            state <= ST_DET;
          end else idx <= idx + 4'd1;
        end
        ST_DET: begin
          if (idx == 4'd0) det <= DW'(dp);
          else if (idx[0]) det <= det + (DW'(dp) <<< EW);
          else det <= det + DW'(dp);
          if (idx == 4'd5) begin
            idx   <= '0;
            state <= ST_DONE;
          end else idx <= idx + 4'd1;
        end
        ST_DONE: if (job_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/m3inv_queue.sv
// Two-entry queue between front and back parts.
module m3inv_queue
  import m3inv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  m3inv_job_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output m3inv_job_t rd_data
);

  m3inv_job_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr_go, rd_go;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_go) mem[wp] <= wr_data;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_go) wp <= ~wp;
      if (rd_go) rp <= ~rp;
      cnt <= cnt + {1'b0, wr_go} - {1'b0, rd_go};
    end
  end

endmodule

// File: rtl/m3inv_back.sv
// Back part: up to nine restoring divisions sharing one bit-serial divider.
module m3inv_back
  import m3inv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  m3inv_job_t job,
  output logic       out_valid,
  input  logic       out_ready,
  output m3inv_out_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;
  localparam int QW  = NW;
  localparam int CW  = $clog2(NW + 1);

  logic [1:0] state;
  logic [3:0] idx;
  logic [CW-1:0] bitcnt;
  logic signed [8:0][AW-1:0] adj;
  logic [DW-1:0] dmag;
  logic dneg, nneg, bad;
  logic [NW-1:0] num;
  logic [DW:0] rem;
  logic [QW-1:0] quo;
  logic signed [8:0][EW-1:0] res;
  logic [DW:0] rsh, rsub;
  logic [AW-1:0] amag;
  logic qneg, ovf;
  logic [QW-1:0] lim;

  assign rsh  = {rem[DW-1:0], num[NW-1]};
  assign rsub = rsh - {1'b0, dmag};
  assign amag = adj[idx][AW-1] ? (~adj[idx] + AW'(1)) : adj[idx];
  assign qneg = nneg ^ dneg;
  assign lim  = QW'(1) << (EW - 1);
  assign ovf  = qneg ? (quo > lim) : (quo >= lim);

  assign job_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    out_data.inv00 = bad ? '0 : res[0];
    out_data.inv01 = bad ? '0 : res[1];
    out_data.inv02 = bad ? '0 : res[2];
    out_data.inv10 = bad ? '0 : res[3];
    out_data.inv11 = bad ? '0 : res[4];
    out_data.inv12 = bad ? '0 : res[5];
    out_data.inv20 = bad ? '0 : res[6];
    out_data.inv21 = bad ? '0 : res[7];
    out_data.inv22 = bad ? '0 : res[8];
    out_data.ok    = ~bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      bad   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (job_valid) begin
          adj   <= job.adj;
          dneg  <= job.det[DW-1];
          dmag  <= job.det[DW-1] ? (~job.det + DW'(1)) : job.det;
          bad   <= (job.det == '0);
          idx   <= '0;
          state <= (job.det == '0) ? ST_OUT : ST_LOAD;
        end
        ST_LOAD: begin
          nneg   <= adj[idx][AW-1];
          num    <= {amag, {(2 * FB){1'b0}}};
          rem    <= '0;
          quo    <= '0;
          bitcnt <= CW'(NW);
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (bitcnt != '0) begin
            num    <= num << 1;
            bitcnt <= bitcnt - CW'(1);
            if (!rsub[DW]) begin
              rem <= rsub;
              quo <= {quo[QW-2:0], 1'b1};
            end else begin
              rem <= rsh;
              quo <= {quo[QW-2:0], 1'b0};
            end
          end else begin
            res[idx] <= qneg ? EW'(~quo + QW'(1)) : EW'(quo);
            if (ovf) begin
              bad   <= 1'b1;
              state <= ST_OUT;
            end else if (idx == 4'd8) begin
              state <= ST_OUT;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_LOAD;
            end
          end
        end
        ST_OUT: if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/m3inv_checker.sv
// Port-level checks for the matrix inverse unit, bound to the top level.
module m3inv_checker
  import m3inv_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input m3inv_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.inv00 == '0 && out_data.inv11 == '0
      && out_data.inv22 == '0)
    else $error("failed result not zeroed");

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready the cycle after accept");

endmodule

bind matrix3_inverse_unit m3inv_checker u_m3inv_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
